// ----- rtl/spectrum_bin_peak_energy_detect_defines.svh -----
// Assertion macros shared by the RTL files.
// Both macros expect a signal named clk; SBPED_ASSERT also expects rst.
`ifndef SPECTRUM_BIN_PEAK_ENERGY_DETECT_DEFINES_SVH
`define SPECTRUM_BIN_PEAK_ENERGY_DETECT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define SBPED_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define SBPED_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBPED_ASSERT(name, prop, msg)
`define SBPED_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- rtl/sbped_pkg.sv -----
package sbped_pkg;

  localparam int VEC_LEN   = 1024;
  localparam int BIN_W     = $clog2(VEC_LEN);
  localparam int MID_START = VEC_LEN / 4;
  localparam int MID_STOP  = VEC_LEN - MID_START;
  localparam int MID_COUNT = MID_STOP - MID_START;
  // middle-half count is a power of two: floor mean is an arithmetic shift
  localparam int MID_SHIFT = $clog2(MID_COUNT);
  localparam int SUM_W     = 44;
  localparam int PWR_W     = 32;
  localparam int CNT_W     = 16;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  localparam logic [1:0] KIND_BIN  = 2'd0;
  localparam logic [1:0] KIND_TUNE = 2'd1;
  localparam logic [1:0] KIND_CONT = 2'd2;

  localparam logic CFG_TUNE  = 1'b0;
  localparam logic CFG_DWELL = 1'b1;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_TUNE,
    PH_DWELL,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [PWR_W-1:0] sample_power;
    logic                    end_of_vector;
  } item_t;

  typedef struct packed {
    logic signed [PWR_W-1:0] avg_power;
    logic                    rejected;
  } result_t;

  // work handed from the control stage to the bin update stage
  typedef struct packed {
    logic                    valid;
    logic                    upd;    // element of a dwell vector
    logic                    first;  // first dwell vector: held max is zero
    logic                    add;    // middle bin of the last dwell vector
    logic                    emit;   // last element of the dwell
    logic                    clear;  // dwell starts: clear the sum first
    logic                    rej;    // command outside idle
    logic [BIN_W-1:0]        bin;
    logic signed [PWR_W-1:0] x;
  } op_t;

endpackage

// ----- rtl/sbped_ram.sv -----
module sbped_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sbped_ctrl.sv -----
`include "spectrum_bin_peak_energy_detect_defines.svh"

module sbped_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  sbped_pkg::item_t           item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sbped_pkg::CNT_W-1:0] cfg_data,
  output logic [sbped_pkg::BIN_W-1:0] rd_addr,
  output sbped_pkg::op_t             op
);
  import sbped_pkg::*;

  phase_t           phase, phase_next;
  phase_t           vector_phase, vector_phase_next;
  logic [CNT_W-1:0] vectors_left, vectors_left_next;
  logic [BIN_W-1:0] bin_position, bin_position_next;
  logic             first_dwell, first_dwell_next;
  logic [CNT_W-1:0] tune_vectors, dwell_vectors;
  logic [CNT_W-1:0] dwell_len;
  op_t              op_next;

  assign dwell_len = (dwell_vectors == '0) ? CNT_W'(1) : dwell_vectors;
  assign rd_addr   = bin_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      tune_vectors  <= '0;
      dwell_vectors <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TUNE:  tune_vectors  <= cfg_data;
        CFG_DWELL: dwell_vectors <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_INIT;
      vector_phase <= PH_INIT;
      vectors_left <= '0;
      bin_position <= '0;
      first_dwell  <= 1'b0;
      op           <= '0;
    end else begin
      phase        <= phase_next;
      vector_phase <= vector_phase_next;
      vectors_left <= vectors_left_next;
      bin_position <= bin_position_next;
      first_dwell  <= first_dwell_next;
      op           <= op_next;
    end
  end

  always_comb begin
    phase_t ph;
    phase_t vp;
    logic   last;
    logic   mid;
    ph                = phase;
    vp                = vector_phase;
    last              = 1'b0;
    mid               = (bin_position >= BIN_W'(MID_START)) &&
                        (bin_position < BIN_W'(MID_STOP));
    phase_next        = phase;
    vector_phase_next = vector_phase;
    vectors_left_next = vectors_left;
    bin_position_next = bin_position;
    first_dwell_next  = first_dwell;
    op_next           = '0;
    op_next.bin       = bin_position;
    op_next.x         = item.sample_power;

    if (accept) begin
      if (item.kind != KIND_BIN) begin
        if (phase != PH_IDLE) begin
          op_next.valid = 1'b1;
          op_next.rej   = 1'b1;
        end else if (item.kind == KIND_TUNE) begin
          phase_next = PH_INIT;
        end else if (item.kind == KIND_CONT) begin
          phase_next        = PH_DWELL;
          vectors_left_next = dwell_len;
          first_dwell_next  = 1'b1;
          op_next.valid     = 1'b1;
          op_next.clear     = 1'b1;
        end
      end else begin
        op_next.valid = 1'b1;
        // phase is latched for the vector at its first element
        if (bin_position == '0) begin
          if (ph == PH_INIT) begin
            ph                = PH_TUNE;
            vectors_left_next = tune_vectors;
            if (tune_vectors == '0) begin
              ph                = PH_DWELL;
              vectors_left_next = dwell_len;
              first_dwell_next  = 1'b1;
              op_next.clear     = 1'b1;
            end
          end
          vp = ph;
        end
        vector_phase_next = vp;

        op_next.upd   = (vp == PH_DWELL);
        op_next.first = first_dwell_next;
        op_next.add   = (vp == PH_DWELL) && (vectors_left_next < CNT_W'(2)) && mid;

        last = item.end_of_vector || (bin_position == BIN_W'(VEC_LEN - 1));
        if (!last) begin
          bin_position_next = bin_position + BIN_W'(1);
        end else begin
          bin_position_next = '0;
          unique case (vp)
            PH_TUNE: begin
              if (vectors_left_next != '0) begin
                vectors_left_next = vectors_left_next - CNT_W'(1);
              end
              if (vectors_left_next == '0) begin
                ph                = PH_DWELL;
                vectors_left_next = dwell_len;
                first_dwell_next  = 1'b1;
                op_next.clear     = 1'b1;
              end
            end
            PH_DWELL: begin
              if (vectors_left_next < CNT_W'(2)) begin
                op_next.emit      = 1'b1;
                vectors_left_next = '0;
                ph                = PH_IDLE;
              end else begin
                vectors_left_next = vectors_left_next - CNT_W'(1);
                first_dwell_next  = 1'b0;
              end
            end
            PH_INIT, PH_IDLE: ;
            default: ;
          endcase
        end
        phase_next = ph;
      end
    end
  end

  `SBPED_ASSERT(a_emit_goes_idle, op.valid && op.emit |-> phase == PH_IDLE,
    "dwell result issued but phase is not idle")
  `SBPED_ASSERT(a_busy_cmd_rejected,
    accept && item.kind != KIND_BIN && phase != PH_IDLE |=> op.valid && op.rej,
    "command outside idle was not rejected")

endmodule

// ----- rtl/sbped_bin_update.sv -----
module sbped_bin_update (
  input  logic                        clk,
  input  logic                        rst,
  input  sbped_pkg::op_t              op,
  input  logic [sbped_pkg::BIN_W-1:0] rd_addr,
  input  logic [sbped_pkg::PWR_W-1:0] rdata,
  output logic                        we,
  output logic [sbped_pkg::BIN_W-1:0] waddr,
  output logic [sbped_pkg::PWR_W-1:0] wdata,
  output logic                        res_valid,
  output sbped_pkg::result_t          res
);
  import sbped_pkg::*;

  logic                    fwd_hit;
  logic [PWR_W-1:0]        fwd_data;
  logic signed [PWR_W-1:0] held;
  logic signed [PWR_W-1:0] nv;
  logic signed [SUM_W-1:0] power_sum, power_sum_next;
  logic signed [SUM_W-1:0] mean;

  // back-to-back access to the same bin: take the value just written
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= we && (waddr == rd_addr);
    end
    fwd_data <= wdata;
  end

  always_comb begin
    if (op.first) begin
      held = '0;
    end else if (fwd_hit) begin
      held = signed'(fwd_data);
    end else begin
      held = signed'(rdata);
    end
    nv = (op.x > held) ? op.x : held;
  end

  assign we    = op.valid && op.upd;
  assign waddr = op.bin;
  assign wdata = nv;

  always_comb begin
    power_sum_next = power_sum;
    if (op.valid) begin
      if (op.clear) begin
        power_sum_next = '0;
      end
      if (op.add) begin
        power_sum_next = power_sum_next + SUM_W'(nv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_sum <= '0;
    end else begin
      power_sum <= power_sum_next;
    end
  end

  assign mean          = power_sum_next >>> MID_SHIFT;
  assign res_valid     = op.valid && (op.emit || op.rej);
  assign res.avg_power = op.rej ? '0 : mean[PWR_W-1:0];
  assign res.rejected  = op.rej;

endmodule

// ----- rtl/sbped_out_fifo.sv -----
`include "spectrum_bin_peak_energy_detect_defines.svh"

module sbped_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  sbped_pkg::result_t              din,
  input  logic                            pop,
  output sbped_pkg::result_t              dout,
  output logic [sbped_pkg::OUT_CNT_W-1:0] count
);
  import sbped_pkg::*;

  result_t              slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] head, tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + OUT_PTR_W'(1);
      end
      if (pop) begin
        head <= head + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= din;
    end
  end

  assign dout = slots[head];

  `SBPED_ASSERT(a_no_overflow, push && !pop |-> count != OUT_CNT_W'(OUT_DEPTH),
    "result queue overflow")
  `SBPED_ASSERT(a_no_underflow, pop |-> count != '0,
    "result queue underflow")

endmodule

// ----- rtl/spectrum_bin_peak_energy_detect.sv -----
// Spectrum bin peak-hold energy detector.
// Item channel (item_valid / item_stall / item): one transfer per bin element
// or command; kind 0 is a Q16.16 bin power, end_of_vector closes a vector.
// Kind 1 retunes, kind 2 starts a new dwell; both are honored only in idle,
// otherwise they return a result with rejected set and avg_power zero.
// Result channel (result_valid / result_stall / result): avg_power is the
// floor mean of the per-bin maxima over the middle half of the bins.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// tune_vectors, index 1 is dwell_vectors; cfg_ready is always high.
// Throughput: one item per clock while item_stall is low. Bin maxima live in a
// 1024 x 32 RAM that is read when the item is taken and written the next cycle;
// a same-bin access in consecutive cycles is served by forwarding.
// A result is formed from the registered op and then queued in the result buffer.
// Results queue in a 4-entry buffer; item_stall rises once three results
// could be waiting, so a stalled receiver backs up the item side.
// Reset: tune_vectors 0, dwell_vectors 1, detector awaits its tune count.
// The bin RAM is not cleared; a dwell starts from zero maxima anyway.
module spectrum_bin_peak_energy_detect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  sbped_pkg::item_t            item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output sbped_pkg::result_t          result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [sbped_pkg::CNT_W-1:0] cfg_data
);
  import sbped_pkg::*;

  logic                 accept;
  logic                 pop;
  op_t                  op;
  logic [BIN_W-1:0]     rd_addr;
  logic [PWR_W-1:0]     rdata;
  logic                 ram_we;
  logic [BIN_W-1:0]     ram_waddr;
  logic [PWR_W-1:0]     ram_wdata;
  logic                 res_valid;
  result_t              res;
  logic [OUT_CNT_W-1:0] fill;
  logic                 res_pending;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && !item_stall;
  assign pop       = result_valid && !result_stall;

  // queued results plus the one that may land next cycle must leave room
  assign res_pending = op.valid && (op.emit || op.rej);
  assign item_stall  = (fill + OUT_CNT_W'(res_pending)) >= OUT_CNT_W'(OUT_DEPTH - 1);

  sbped_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_addr   (rd_addr),
    .op        (op)
  );

  sbped_ram #(
    .WIDTH (PWR_W),
    .DEPTH (VEC_LEN)
  ) u_bin_max (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  sbped_bin_update u_update (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .rd_addr   (rd_addr),
    .rdata     (rdata),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  sbped_out_fifo u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .pop   (pop),
    .dout  (result),
    .count (fill)
  );

  assign result_valid = (fill != '0);

  `SBPED_ASSERT_ALWAYS(a_reset_empties, $past(rst) |-> !result_valid,
    "result pending right after reset")

endmodule
